>>> src/grc_pkg.sv
// Shared constants, word formats and unit interfaces of the grid raycast block.
// No dependencies.
package grc_pkg;

    localparam int MAP_SIDE_DEF   = 8;
    localparam int CELL_SIZE_DEF  = 64;
    localparam int MAX_STEPS_DEF  = 8;
    localparam int ANGLE_BITS_DEF = 12;

    localparam int POS_W  = 15;
    localparam int DIST_W = 20;
    localparam int PH_W   = 10;
    localparam int MAP_W  = 64;
    localparam int CFG_IDX_W = 1;

    localparam int HIT_W  = 18;
    localparam int SQ_W   = 19;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int DVD_W  = 47;
    localparam int DSR_W  = 31;
    localparam int MUL_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WALL_MAP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_HEIGHT = 1'b1;

    localparam logic [PH_W-1:0] PH_RESET = 10'd320;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] SC1 = 31'd1686629713;
    localparam logic [30:0] SC3 = 31'd693598666;
    localparam logic [30:0] SC5 = 31'd85569305;
    localparam logic [30:0] SC7 = 31'd5026995;
    localparam logic [30:0] SC9 = 31'd172272;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic            done;
        logic [SQ_W-1:0] root;
    } t_sqrt_rsp;

endpackage

>>> src/grc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for widths and request/response structs.
module grc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grc_pkg::t_div_req i_req,
    output grc_pkg::t_div_rsp o_rsp
);
    localparam int DVD_W = grc_pkg::DVD_W;
    localparam int DSR_W = grc_pkg::DSR_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= fits ? DSR_W'(trial - {1'b0, r_dsr}) : trial[DSR_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> src/grc_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on grc_pkg for widths and request/response structs.
module grc_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grc_pkg::t_sqrt_req i_req,
    output grc_pkg::t_sqrt_rsp o_rsp
);
    localparam int RAD_W = grc_pkg::RAD_W;
    localparam int SQ_W  = grc_pkg::SQ_W;

    logic             r_busy;
    logic             r_done;
    logic [RAD_W-1:0] r_rem;
    logic [RAD_W-1:0] r_res;
    logic [RAD_W-1:0] r_bit;
    logic [RAD_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.radicand;
                r_res  <= '0;
                r_bit  <= RAD_W'(1) << (RAD_W - 2);
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[SQ_W-1:0];

endmodule

>>> src/grid_raycast_column.sv
// Grid raycaster: one ray per input word, one result word per ray.
// Steps in order: trig, a slope division per family (skipped when the ray runs parallel to
// that family), grid walk per family, distance per hit family (square root), correction,
// slice division (skipped at zero distance), then the output load, which waits while the
// output stalls. A new ray is taken only after the last result is loaded; input ready only
// while idle. Sync active-low reset: control, wall_map 0, height 320.
module grid_raycast_column #(
    parameter int MAP_SIDE   = grc_pkg::MAP_SIDE_DEF,
    parameter int CELL_SIZE  = grc_pkg::CELL_SIZE_DEF,
    parameter int MAX_STEPS  = grc_pkg::MAX_STEPS_DEF,
    parameter int ANGLE_BITS = grc_pkg::ANGLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [grc_pkg::POS_W-1:0]       i_pos_x,
    input  logic [grc_pkg::POS_W-1:0]       i_pos_y,
    input  logic [ANGLE_BITS-1:0]           i_ray_angle,
    input  logic [ANGLE_BITS-1:0]           i_view_angle,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [grc_pkg::POS_W-1:0]       o_hit_x,
    output logic [grc_pkg::POS_W-1:0]       o_hit_y,
    output logic [grc_pkg::DIST_W-1:0]      o_corrected_distance,
    output logic [grc_pkg::PH_W-1:0]        o_wall_height,
    output logic [grc_pkg::PH_W-2:0]        o_wall_top,
    output logic                            o_hit_side,
    output logic                            o_no_hit,
    input  logic                            i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [grc_pkg::MAP_W-1:0]       i_cfg_data
);
    localparam int AB    = ANGLE_BITS;
    localparam int POS_W = grc_pkg::POS_W;
    localparam int PH_W  = grc_pkg::PH_W;
    localparam int HIT_W = grc_pkg::HIT_W;
    localparam int SQ_W  = grc_pkg::SQ_W;
    localparam int RAD_W = grc_pkg::RAD_W;
    localparam int DVD_W = grc_pkg::DVD_W;
    localparam int DSR_W = grc_pkg::DSR_W;
    localparam int MUL_W = grc_pkg::MUL_W;
    localparam int DIST_W = grc_pkg::DIST_W;
    localparam int CELLQ = CELL_SIZE * 64;
    localparam int MAPQ  = MAP_SIDE * CELLQ;
    localparam int BMAX  = 32767 / CELLQ;
    localparam int KW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LW    = 8;
    localparam int LPW   = 24;
    localparam int DLW   = 25;
    localparam int LSW   = 50;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_TRIG = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_WALK = 9'b000001000,
        ST_DIST = 9'b000010000,
        ST_SQRT = 9'b000100000,
        ST_CORR = 9'b001000000,
        ST_HDIV = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    function automatic logic [POS_W-1:0] sat15(input logic [HIT_W-1:0] v);
        return (|v[HIT_W-1:POS_W]) ? '1 : v[POS_W-1:0];
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] a;
        a = v[31] ? 32'(-v) : 32'(v);
        return a[30:0];
    endfunction

    t_state r_state;
    logic   r_ph;
    logic [2:0] r_step;
    logic [1:0] r_tsel;
    logic       r_fam;
    logic [KW-1:0] r_k;

    logic [grc_pkg::MAP_W-1:0] r_wall;
    logic [PH_W-1:0]           r_proj_h;

    logic [POS_W-1:0] r_px, r_py;
    logic [AB-1:0]    r_ra, r_va;
    logic signed [31:0] r_sin, r_cos, r_cv;
    logic [30:0] r_z2, r_p;
    logic [2*MUL_W-1:0] r_prod;
    logic [MUL_W-1:0] r_rcot, r_rtan;
    logic r_hh, r_hv;
    logic [HIT_W-1:0] r_hx, r_hy, r_vx, r_vy;
    logic [RAD_W-1:0] r_acc;
    logic [SQ_W-1:0]  r_dh, r_dv;
    logic [DIST_W-1:0] r_corr;
    logic [PH_W-1:0]   r_height;

    logic r_ovalid;
    logic [POS_W-1:0]  r_o_hit_x, r_o_hit_y;
    logic [DIST_W-1:0] r_o_dist;
    logic [PH_W-1:0]   r_o_height;
    logic [PH_W-2:0]   r_o_top;
    logic r_o_side, r_o_nohit;

    grc_pkg::t_div_req  div_req;
    grc_pkg::t_div_rsp  div_rsp;
    grc_pkg::t_sqrt_req sq_req;
    grc_pkg::t_sqrt_rsp sq_rsp;

    logic [MUL_W-1:0] mul_a, mul_b;

    // trig argument fold
    logic [AB-1:0] t_ang;
    logic [AB-2:0] t_fold;
    logic [30:0]   t_z;
    logic [30:0]   t_sc;
    logic [33:0]   t_s_hi;
    logic [30:0]   t_s;

    always_comb begin
        case (r_tsel)
            2'd1:    t_ang = r_ra + AB'(1 << (AB - 2));
            2'd2:    t_ang = r_va - r_ra + AB'(1 << (AB - 2));
            default: t_ang = r_ra;
        endcase
        if (t_ang[AB-2])
            t_fold = (AB-1)'(1 << (AB - 2)) - (AB-1)'(t_ang[AB-3:0]);
        else
            t_fold = (AB-1)'(t_ang[AB-3:0]);
        t_z = 31'(t_fold) << (32 - AB);
        case (r_step)
            3'd1:    t_sc = grc_pkg::SC7;
            3'd2:    t_sc = grc_pkg::SC5;
            3'd3:    t_sc = grc_pkg::SC3;
            default: t_sc = grc_pkg::SC1;
        endcase
        t_s_hi = r_prod[63:30];
        t_s    = (t_s_hi > 34'(grc_pkg::Q30_ONE)) ? grc_pkg::Q30_ONE : r_prod[60:30];
    end

    // grid walk datapath
    logic sin_pos, cos_pos, rneg, fam_en;
    logic [POS_W-1:0] w_prim, w_sec;
    logic w_dirp;
    logic [5:0] w_base;
    logic signed [LW-1:0]  w_line, w_cp;
    logic signed [LPW-1:0] w_lp;
    logic signed [DLW-1:0] w_delta;
    logic [DLW-1:0] w_dabs;
    logic w_neg;
    logic signed [LSW-1:0] w_ls, w_sec_s, w_m;
    logic [2:0] w_cs;
    logic [5:0] w_idx;
    logic w_cell_ok, w_hit;

    assign sin_pos = !r_sin[31] && (r_sin != 32'sd0);
    assign cos_pos = !r_cos[31] && (r_cos != 32'sd0);
    assign rneg    = r_sin[31] ^ r_cos[31];

    always_comb begin
        w_prim = r_fam ? r_px : r_py;
        w_sec  = r_fam ? r_py : r_px;
        w_dirp = r_fam ? cos_pos : sin_pos;
        w_base = '0;
        for (int b = 1; b <= BMAX; b++) begin
            if (16'(w_prim) >= 16'(b * CELLQ))
                w_base = 6'(b);
        end
        if (w_dirp)
            w_line = LW'(w_base) + LW'(r_k) + LW'(1);
        else
            w_line = LW'(w_base) - LW'(r_k);
        w_cp    = w_dirp ? w_line : w_line - LW'(1);
        w_lp    = LPW'(w_line) * LPW'(CELLQ);
        w_delta = DLW'(w_lp) - DLW'($signed({1'b0, w_prim}));
        w_dabs  = w_delta[DLW-1] ? DLW'(-w_delta) : DLW'(w_delta);
        w_neg   = w_delta[DLW-1] ^ rneg;
        w_sec_s = LSW'($signed({1'b0, w_sec}));
        w_m     = LSW'($signed({1'b0, r_prod[63:16]}));
        w_ls    = w_neg ? w_sec_s - w_m : w_sec_s + w_m;
        w_cs    = '0;
        for (int j = 1; j < MAP_SIDE; j++) begin
            if (w_ls >= LSW'(j * CELLQ))
                w_cs = 3'(j);
        end
        w_cell_ok = !w_cp[LW-1] && (w_cp < LW'(MAP_SIDE)) && !w_ls[LSW-1]
                    && (w_ls < LSW'(MAPQ));
        if (r_fam)
            w_idx = 6'(w_cs) * 6'(MAP_SIDE) + 6'(w_cp[2:0]);
        else
            w_idx = 6'(w_cp[2:0]) * 6'(MAP_SIDE) + 6'(w_cs);
        w_hit = w_cell_ok && r_wall[w_idx];
    end

    // distance and selection
    logic [HIT_W-1:0] d_hx, d_hy, d_ex, d_ey;
    logic sel_v, no_hit, cv_pos;
    logic [SQ_W-1:0] d_sel;
    logic [DIST_W-1:0] c_corr;

    always_comb begin
        d_hx = r_fam ? r_vx : r_hx;
        d_hy = r_fam ? r_vy : r_hy;
        d_ex = (d_hx > HIT_W'(r_px)) ? d_hx - HIT_W'(r_px) : HIT_W'(r_px) - d_hx;
        d_ey = (d_hy > HIT_W'(r_py)) ? d_hy - HIT_W'(r_py) : HIT_W'(r_py) - d_hy;
        no_hit = !r_hh && !r_hv;
        sel_v  = r_hv && (!r_hh || (r_dv < r_dh));
        d_sel  = sel_v ? r_dv : r_dh;
        cv_pos = !r_cv[31] && (r_cv != 32'sd0);
        if (!cv_pos)
            c_corr = '0;
        else if (|r_prod[63:50])
            c_corr = '1;
        else
            c_corr = r_prod[49:30];
    end

    assign fam_en = (r_state == ST_WALK || r_state == ST_DIV)
                    ? (r_fam ? (r_cos != 32'sd0) : (r_sin != 32'sd0))
                    : (r_fam ? r_hv : r_hh);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_TRIG: begin
                case (r_step)
                    3'd0:    begin mul_a = 32'(t_z);  mul_b = 32'(t_z); end
                    3'd5:    begin mul_a = 32'(t_z);  mul_b = 32'(r_p); end
                    default: begin mul_a = 32'(r_z2); mul_b = 32'(r_p); end
                endcase
            end
            ST_WALK: begin
                mul_a = 32'(w_dabs);
                mul_b = r_fam ? r_rtan : r_rcot;
            end
            ST_DIST: begin
                mul_a = r_step[0] ? 32'(d_ey) : 32'(d_ex);
                mul_b = r_step[0] ? 32'(d_ey) : 32'(d_ex);
            end
            ST_CORR: begin
                mul_a = 32'(d_sel);
                mul_b = 32'(r_cv[30:0]);
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (r_state == ST_DIV && !r_ph && fam_en) begin
            div_req.start    = 1'b1;
            div_req.dividend = {r_fam ? mag31(r_sin) : mag31(r_cos), 16'b0};
            div_req.divisor  = r_fam ? mag31(r_cos) : mag31(r_sin);
        end else if (r_state == ST_HDIV && !r_ph && (r_corr != '0)) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(r_proj_h) * DVD_W'(CELLQ);
            div_req.divisor  = DSR_W'(r_corr);
        end
        sq_req.start    = (r_state == ST_DIST) && r_ph && r_step[0];
        sq_req.radicand = r_acc + r_prod[RAD_W-1:0];
    end

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    grc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    logic load_out;
    logic [PH_W-1:0] o_h;

    assign load_out = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);
    assign o_h      = no_hit ? '0 : r_height;

    always_ff @(posedge i_clk) begin
        if (!r_ph)
            r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ph     <= 1'b0;
            r_ovalid <= 1'b0;
            r_wall   <= '0;
            r_proj_h <= grc_pkg::PH_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    grc_pkg::CFG_WALL_MAP:    r_wall   <= i_cfg_data;
                    grc_pkg::CFG_PROJ_HEIGHT: r_proj_h <= i_cfg_data[PH_W-1:0];
                    default: ;
                endcase
            end
            if (load_out)
                r_ovalid <= 1'b1;
            else if (i_out_ready)
                r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_px   <= i_pos_x;
                        r_py   <= i_pos_y;
                        r_ra   <= i_ray_angle;
                        r_va   <= i_view_angle;
                        r_hh   <= 1'b0;
                        r_hv   <= 1'b0;
                        r_step <= '0;
                        r_tsel <= '0;
                        r_ph   <= 1'b0;
                        r_state <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_step <= r_step + 3'd1;
                        case (r_step)
                            3'd0: begin
                                r_z2 <= r_prod[60:30];
                                r_p  <= grc_pkg::SC9;
                            end
                            3'd5: begin
                                r_step <= '0;
                                case (r_tsel)
                                    2'd0:    r_sin <= t_ang[AB-1] ? -$signed({1'b0, t_s})
                                                                  : $signed({1'b0, t_s});
                                    2'd1:    r_cos <= t_ang[AB-1] ? -$signed({1'b0, t_s})
                                                                  : $signed({1'b0, t_s});
                                    default: r_cv  <= t_ang[AB-1] ? -$signed({1'b0, t_s})
                                                                  : $signed({1'b0, t_s});
                                endcase
                                r_tsel <= r_tsel + 2'd1;
                                if (r_tsel == 2'd2) begin
                                    r_fam   <= 1'b0;
                                    r_state <= ST_DIV;
                                end
                            end
                            default: r_p <= t_sc - r_prod[60:30];
                        endcase
                    end
                end
                ST_DIV: begin
                    if (!r_ph && fam_en) begin
                        r_ph <= 1'b1;
                    end else if (!r_ph || div_rsp.done) begin
                        r_ph <= 1'b0;
                        if (r_ph) begin
                            if (r_fam)
                                r_rtan <= div_rsp.quotient[MUL_W-1:0];
                            else
                                r_rcot <= div_rsp.quotient[MUL_W-1:0];
                        end
                        r_fam <= !r_fam;
                        r_k   <= '0;
                        if (r_fam)
                            r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (!r_ph && fam_en) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (!r_ph || w_hit || r_k == KW'(MAX_STEPS - 1)) begin
                            if (r_ph && w_hit) begin
                                if (r_fam) begin
                                    r_hv <= 1'b1;
                                    r_vx <= HIT_W'(w_lp);
                                    r_vy <= HIT_W'(w_ls);
                                end else begin
                                    r_hh <= 1'b1;
                                    r_hy <= HIT_W'(w_lp);
                                    r_hx <= HIT_W'(w_ls);
                                end
                            end
                            r_k    <= '0;
                            r_fam  <= !r_fam;
                            r_step <= '0;
                            if (r_fam)
                                r_state <= ST_DIST;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                ST_DIST: begin
                    if (!fam_en) begin
                        r_fam <= 1'b0;
                        if (r_fam)
                            r_state <= ST_CORR;
                        else
                            r_fam <= 1'b1;
                    end else begin
                        r_ph <= !r_ph;
                        if (r_ph) begin
                            if (!r_step[0]) begin
                                r_acc  <= r_prod[RAD_W-1:0];
                                r_step <= 3'd1;
                            end else begin
                                r_step  <= '0;
                                r_state <= ST_SQRT;
                            end
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq_rsp.done) begin
                        if (r_fam) begin
                            r_dv    <= sq_rsp.root;
                            r_fam   <= 1'b0;
                            r_state <= ST_CORR;
                        end else begin
                            r_dh    <= sq_rsp.root;
                            r_fam   <= 1'b1;
                            r_state <= ST_DIST;
                        end
                    end
                end
                ST_CORR: begin
                    if (no_hit) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ph <= !r_ph;
                        if (r_ph) begin
                            r_corr  <= c_corr;
                            r_state <= ST_HDIV;
                        end
                    end
                end
                ST_HDIV: begin
                    if (!r_ph) begin
                        if (r_corr == '0) begin
                            r_height <= r_proj_h;
                            r_state  <= ST_OUT;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else if (div_rsp.done) begin
                        r_ph <= 1'b0;
                        if (div_rsp.quotient > DVD_W'(r_proj_h))
                            r_height <= r_proj_h;
                        else
                            r_height <= div_rsp.quotient[PH_W-1:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_o_hit_x  <= no_hit ? r_px : sat15(sel_v ? r_vx : r_hx);
                        r_o_hit_y  <= no_hit ? r_py : sat15(sel_v ? r_vy : r_hy);
                        r_o_dist   <= no_hit ? '1 : r_corr;
                        r_o_height <= o_h;
                        r_o_top    <= r_proj_h[PH_W-1:1] - o_h[PH_W-1:1];
                        r_o_side   <= !no_hit && sel_v;
                        r_o_nohit  <= no_hit;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready           = (r_state == ST_IDLE);
    assign o_out_valid          = r_ovalid;
    assign o_hit_x              = r_o_hit_x;
    assign o_hit_y              = r_o_hit_y;
    assign o_corrected_distance = r_o_dist;
    assign o_wall_height        = r_o_height;
    assign o_wall_top           = r_o_top;
    assign o_hit_side           = r_o_side;
    assign o_no_hit             = r_o_nohit;

endmodule

>>> src/grc_checker.sv
// Port-level checks for grid_raycast_column, attached by bind.
// Depends on grc_pkg for port widths.
module grc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [grc_pkg::POS_W-1:0]     o_hit_x,
    input logic [grc_pkg::DIST_W-1:0]    o_corrected_distance,
    input logic [grc_pkg::PH_W-1:0]      o_wall_height,
    input logic                          o_hit_side,
    input logic                          o_no_hit
);

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accepting a word");

    a_no_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_hit |->
            o_wall_height == '0 && o_corrected_distance == '1 && !o_hit_side)
        else $error("no-hit word carries hit fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_corrected_distance) && $stable(o_hit_x))
        else $error("stalled output word changed");

endmodule

bind grid_raycast_column grc_checker u_grc_checker (.*);
